// ===== hdl/pdc_pkg.sv =====
package pdc_pkg;

	localparam int SYM_W = 12;
	localparam int KEY_W = 2 * SYM_W;
	localparam int CNT_W = 32;

	localparam logic [CNT_W-1:0] CNT_MAX   = '1;
	localparam logic [31:0]      HASH_MULT = 32'd2654435761;

	localparam logic MODE_COUNT  = 1'b0;
	localparam logic MODE_LOOKUP = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_HEAD,
		ST_PROBE
	} pdc_state_t;

endpackage

// ===== hdl/pair_dictionary_counter.sv =====
// Pair dictionary with occurrence counts. Each input transfer carries a pair
// (symbol_a, symbol_b) and a mode in tuser: count (insert or increment) or lookup
// only. New pairs get dense entry indexes in order of first appearance and start
// at a count of 1; counts saturate at all ones. Pairs are found through hashed
// chains: a bucket memory holds the chain heads and an entry memory holds one row
// {next link, key, count} per entry. An item walks its chain one entry at a time,
// since the single entry-memory read port follows one link per cycle. One item is
// in flight at a time; the next is taken while the result waits in the output
// register. After reset the whole bucket memory is cleared, and no input is
// accepted until the clearing is done.
module pair_dictionary_counter
	import pdc_pkg::*;
#(
	parameter int TABLE_DEPTH  = 4096,
	parameter int HASH_BUCKETS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // symbol_a[11:0], symbol_b[23:12]
	input  logic        s_axis_tuser,  // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // entry_index[11:0], pair_count[43:12], zero pad
	output logic [2:0]  m_axis_tuser   // found[0], created[1], table_full[2]
);

	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int LINK_W = $clog2(TABLE_DEPTH + 1);
	localparam int BKT_W  = $clog2(HASH_BUCKETS);
	localparam int ROW_W  = LINK_W + KEY_W + CNT_W;

	pdc_state_t state_q, state_nx;

	logic                 in_fire;
	logic                 out_free;
	logic [KEY_W-1:0]     key_q;
	logic                 mode_q;
	logic [BKT_W-1:0]     hash_bucket;
	logic [BKT_W-1:0]     bucket_q;
	logic [LINK_W-1:0]    link_q, link_nx;
	logic                 link_ld;
	logic [LINK_W-1:0]    head_q;
	logic [LINK_W-1:0]    used_q;
	logic                 used_inc;
	logic [BKT_W-1:0]     clr_q;

	logic                 bkt_re, bkt_we;
	logic [BKT_W-1:0]     bkt_raddr, bkt_waddr;
	logic [LINK_W-1:0]    bkt_rdata, bkt_wdata;

	logic                 ent_re, ent_we;
	logic [IDX_W-1:0]     ent_raddr, ent_waddr;
	logic [ROW_W-1:0]     ent_rdata, ent_wdata;

	logic [LINK_W-1:0]    row_next;
	logic [KEY_W-1:0]     row_key;
	logic [CNT_W-1:0]     row_cnt, cnt_new;
	logic [LINK_W-1:0]    head_m1, link_m1, next_m1, chain_head;

	logic                 out_ld;
	logic [IDX_W-1:0]     res_idx;
	logic                 res_found, res_created, res_full;
	logic [CNT_W-1:0]     res_cnt;
	logic [IDX_W+11:0]    res_idx_ext;

	logic                 out_valid_q;
	logic [11:0]          out_idx_q;
	logic                 out_found_q, out_created_q, out_full_q;
	logic [CNT_W-1:0]     out_cnt_q;

	pdc_hash #(
		.HASH_BUCKETS(HASH_BUCKETS)
	) u_hash (
		.clk   (clk),
		.load  (in_fire),
		.key   ({s_axis_tdata[23:12], s_axis_tdata[11:0]}),
		.bucket(hash_bucket)
	);

	pdc_bucket_mem #(
		.DEPTH (HASH_BUCKETS),
		.DATA_W(LINK_W)
	) u_bucket_mem (
		.clk  (clk),
		.re   (bkt_re),
		.raddr(bkt_raddr),
		.rdata(bkt_rdata),
		.we   (bkt_we),
		.waddr(bkt_waddr),
		.wdata(bkt_wdata)
	);

	pdc_entry_mem #(
		.DEPTH(TABLE_DEPTH),
		.ROW_W(ROW_W)
	) u_entry_mem (
		.clk  (clk),
		.re   (ent_re),
		.raddr(ent_raddr),
		.rdata(ent_rdata),
		.we   (ent_we),
		.waddr(ent_waddr),
		.wdata(ent_wdata)
	);

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	assign row_cnt  = ent_rdata[CNT_W-1:0];
	assign row_key  = ent_rdata[CNT_W +: KEY_W];
	assign row_next = ent_rdata[CNT_W+KEY_W +: LINK_W];
	assign cnt_new  = (mode_q == MODE_COUNT && row_cnt != CNT_MAX) ? row_cnt + 1'b1 : row_cnt;

	assign head_m1  = bkt_rdata - 1'b1;
	assign link_m1  = link_q - 1'b1;
	assign next_m1  = row_next - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx    = state_q;
		s_axis_tready = 1'b0;
		bkt_re      = 1'b0;
		bkt_raddr   = hash_bucket;
		bkt_we      = 1'b0;
		bkt_waddr   = bucket_q;
		bkt_wdata   = used_q + 1'b1;
		ent_re      = 1'b0;
		ent_raddr   = head_m1[IDX_W-1:0];
		ent_we      = 1'b0;
		ent_waddr   = used_q[IDX_W-1:0];
		chain_head  = (state_q == ST_HEAD) ? bkt_rdata : head_q;
		ent_wdata   = {chain_head, key_q, CNT_W'(1)};
		link_ld     = 1'b0;
		link_nx     = bkt_rdata;
		used_inc    = 1'b0;
		out_ld      = 1'b0;
		res_idx     = '0;
		res_found   = 1'b0;
		res_created = 1'b0;
		res_full    = 1'b0;
		res_cnt     = '0;

		case (state_q)
			ST_CLEAR: begin
				bkt_we    = 1'b1;
				bkt_waddr = clr_q;
				bkt_wdata = '0;
				if (clr_q == BKT_W'(HASH_BUCKETS - 1)) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_nx = ST_HASH;
				end
			end
			ST_HASH: begin
				bkt_re   = 1'b1;
				state_nx = ST_HEAD;
			end
			ST_HEAD, ST_PROBE: begin
				if (state_q == ST_HEAD && bkt_rdata != '0) begin
					// start the chain walk at the bucket head
					ent_re   = 1'b1;
					link_ld  = 1'b1;
					state_nx = ST_PROBE;
				end else if (state_q == ST_PROBE && row_key == key_q) begin
					if (out_free) begin
						out_ld    = 1'b1;
						res_idx   = link_m1[IDX_W-1:0];
						res_found = 1'b1;
						res_cnt   = cnt_new;
						ent_we    = (mode_q == MODE_COUNT);
						ent_waddr = link_m1[IDX_W-1:0];
						ent_wdata = {row_next, row_key, cnt_new};
						state_nx  = ST_IDLE;
					end
				end else if (state_q == ST_PROBE && row_next != '0) begin
					// advance one link
					ent_re    = 1'b1;
					ent_raddr = next_m1[IDX_W-1:0];
					link_ld   = 1'b1;
					link_nx   = row_next;
				end else if (out_free) begin
					// miss: append in count mode if there is room
					out_ld   = 1'b1;
					state_nx = ST_IDLE;
					if (mode_q == MODE_COUNT) begin
						if (used_q == LINK_W'(TABLE_DEPTH)) begin
							res_full = 1'b1;
						end else begin
							ent_we      = 1'b1;
							bkt_we      = 1'b1;
							used_inc    = 1'b1;
							res_idx     = used_q[IDX_W-1:0];
							res_created = 1'b1;
							res_cnt     = CNT_W'(1);
						end
					end
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			clr_q  <= '0;
		end else begin
			if (used_inc) begin
				used_q <= used_q + 1'b1;
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			key_q  <= {s_axis_tdata[11:0], s_axis_tdata[23:12]};
			mode_q <= s_axis_tuser;
		end
		if (state_q == ST_HASH) begin
			bucket_q <= hash_bucket;
		end
		if (state_q == ST_HEAD) begin
			head_q <= bkt_rdata;
		end
		if (link_ld) begin
			link_q <= link_nx;
		end
	end

	assign res_idx_ext = {12'b0, res_idx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ld) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			out_idx_q     <= res_idx_ext[11:0];
			out_found_q   <= res_found;
			out_created_q <= res_created;
			out_full_q    <= res_full;
			out_cnt_q     <= res_cnt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0, out_cnt_q, out_idx_q};
	assign m_axis_tuser  = {out_full_q, out_created_q, out_found_q};

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		out_ld |-> (state_q == ST_HEAD || state_q == ST_PROBE))
		else $error("result loaded outside a search state");

	a_created_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata[43:12] == 32'd1))
		else $error("new entry reported with count other than one");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= LINK_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_full_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ld && res_full) |-> (used_q == LINK_W'(TABLE_DEPTH) && mode_q == MODE_COUNT))
		else $error("table full reported with room left");

	a_no_input_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !s_axis_tready)
		else $error("input taken during bucket clearing");

endmodule

// ===== hdl/pdc_hash.sv =====
module pdc_hash
	import pdc_pkg::*;
#(
	parameter int HASH_BUCKETS = 1024
) (
	input  logic                            clk,
	input  logic                            load,
	input  logic [KEY_W-1:0]                key,
	output logic [$clog2(HASH_BUCKETS)-1:0] bucket
);

	localparam int BKT_W  = $clog2(HASH_BUCKETS);
	localparam int BCNT_W = $clog2(HASH_BUCKETS + 1);

	logic [31:0]          prod_s1;
	logic [31:0]          mix;
	logic [15+BCNT_W:0]   scale;

	// first multiply, registered at the input transfer
	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1 <= {{(32-KEY_W){1'b0}}, key} * HASH_MULT;
		end
	end

	// map the upper half onto [0, HASH_BUCKETS) with a multiply-high
	assign mix    = prod_s1 ^ (prod_s1 >> 15);
	assign scale  = {{BCNT_W{1'b0}}, mix[31:16]} * {16'b0, BCNT_W'(HASH_BUCKETS)};
	assign bucket = scale[16 +: BKT_W];

endmodule

// ===== hdl/pdc_bucket_mem.sv =====
module pdc_bucket_mem
	import pdc_pkg::*;
#(
	parameter int DEPTH  = 1024,
	parameter int DATA_W = 13
) (
	input  logic                     clk,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold read data between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/pdc_entry_mem.sv =====
module pdc_entry_mem
	import pdc_pkg::*;
#(
	parameter int DEPTH = 4096,
	parameter int ROW_W = 69
) (
	input  logic                     clk,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [ROW_W-1:0]         rdata,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [ROW_W-1:0]         wdata
);

	logic [ROW_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import pdc_pkg::*;

	localparam int TABLE_DEPTH  = 4096;
	localparam int HASH_BUCKETS = 1024;
	localparam int RANDOM_ITEMS = 1250;
	localparam int SEGMENT_LEN  = 150;
	localparam int FULL_PROBES  = 24;
	localparam int DRAIN_CYCLES = 32;
	localparam int QUIET_LIMIT  = 20000;
	localparam int DIR_N        = 21;

	typedef struct packed {
		logic [SYM_W-1:0] entry_index;
		logic             found;
		logic             created;
		logic [CNT_W-1:0] count;
		logic             full;
	} pair_result_t;

	typedef struct {
		logic             mode;
		logic [SYM_W-1:0] a;
		logic [SYM_W-1:0] b;
		bit               typed;
		pair_result_t     want;
	} directed_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;  // symbol_a[11:0], symbol_b[23:12]
	logic        s_axis_tuser;  // mode
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;  // entry_index[11:0], pair_count[43:12], zero pad
	logic [2:0]  m_axis_tuser;  // found[0], created[1], table_full[2]

	// shadow of the dictionary
	int               entry_of [logic [KEY_W-1:0]];
	logic [CNT_W-1:0] pair_tally [TABLE_DEPTH];
	int               entries_used;
	logic [KEY_W-1:0] known_keys [$];

	pair_result_t results_due [$];
	int           mismatches;
	int           results_seen;
	int           idle_max;
	int           quiet_cycles;

	// empty table: extremes, single bytes, lookups that hit and miss
	directed_row_t directed_rows [DIR_N] = '{
		'{MODE_LOOKUP, 12'd0,    12'd0,    1'b1, '{12'd0, 1'b0, 1'b0, 32'd0, 1'b0}},
		'{MODE_COUNT,  12'd0,    12'd0,    1'b1, '{12'd0, 1'b0, 1'b1, 32'd1, 1'b0}},
		'{MODE_COUNT,  12'd4095, 12'd4095, 1'b1, '{12'd1, 1'b0, 1'b1, 32'd1, 1'b0}},
		'{MODE_COUNT,  12'd0,    12'd0,    1'b1, '{12'd0, 1'b1, 1'b0, 32'd2, 1'b0}},
		'{MODE_LOOKUP, 12'd0,    12'd0,    1'b1, '{12'd0, 1'b1, 1'b0, 32'd2, 1'b0}},
		'{MODE_LOOKUP, 12'd4095, 12'd4095, 1'b1, '{12'd1, 1'b1, 1'b0, 32'd1, 1'b0}},
		'{MODE_COUNT,  12'hFF,   12'd0,    1'b1, '{12'd2, 1'b0, 1'b1, 32'd1, 1'b0}},
		'{MODE_COUNT,  12'd4095, 12'd0,    1'b1, '{12'd3, 1'b0, 1'b1, 32'd1, 1'b0}},
		'{MODE_COUNT,  12'd0,    12'd4095, 1'b1, '{12'd4, 1'b0, 1'b1, 32'd1, 1'b0}},
		'{MODE_LOOKUP, 12'hFF,   12'd0,    1'b1, '{12'd2, 1'b1, 1'b0, 32'd1, 1'b0}},
		'{MODE_LOOKUP, 12'hFF,   12'd1,    1'b1, '{12'd0, 1'b0, 1'b0, 32'd0, 1'b0}},
		'{MODE_COUNT,  12'd2,    12'd3,    1'b0, '0},
		'{MODE_COUNT,  12'h41,   12'd0,    1'b0, '0},
		'{MODE_COUNT,  12'hFF,   12'd0,    1'b0, '0},
		'{MODE_COUNT,  12'd2,    12'd3,    1'b0, '0},
		'{MODE_LOOKUP, 12'd2,    12'd3,    1'b0, '0},
		'{MODE_COUNT,  12'hAAA,  12'h555,  1'b0, '0},
		'{MODE_COUNT,  12'h555,  12'hAAA,  1'b0, '0},
		'{MODE_LOOKUP, 12'h555,  12'h555,  1'b0, '0},
		'{MODE_COUNT,  12'd4095, 12'd4095, 1'b0, '0},
		'{MODE_COUNT,  12'd1,    12'd0,    1'b0, '0}
	};

	pair_dictionary_counter #(
		.TABLE_DEPTH  (TABLE_DEPTH),
		.HASH_BUCKETS (HASH_BUCKETS)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// look up a pair in the shadow dictionary, inserting or incrementing it in count mode, and return the result
	function automatic pair_result_t tally_pair(input logic mode, input logic [SYM_W-1:0] a,
			input logic [SYM_W-1:0] b);
		pair_result_t     r;
		logic [KEY_W-1:0] key;
		int               idx;
		r   = '0;
		key = {a, b};
		if (entry_of.exists(key)) begin
			idx     = entry_of[key];
			r.found = 1'b1;
			if (mode == MODE_COUNT && pair_tally[idx] != CNT_MAX)
				pair_tally[idx] = pair_tally[idx] + 1;
			r.entry_index = idx[SYM_W-1:0];
			r.count       = pair_tally[idx];
		end else if (mode == MODE_COUNT) begin
			if (entries_used >= TABLE_DEPTH) begin
				r.full = 1'b1;
			end else begin
				idx               = entries_used;
				entry_of[key]     = idx;
				pair_tally[idx]   = 1;
				known_keys        = {known_keys, key};
				entries_used      = entries_used + 1;
				r.entry_index     = idx[SYM_W-1:0];
				r.created         = 1'b1;
				r.count           = 1;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got,
			input logic [CNT_W-1:0] want);
		$display("[%0t] result %0d: %s got 0x%0h want 0x%0h", $time, results_seen, what, got,
			want);
		mismatches++;
	endtask

	task automatic check_field(input string what, input logic [CNT_W-1:0] got,
			input logic [CNT_W-1:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// one input transfer; valid stays high when the next item follows with no gap
	task automatic send_pair(input logic mode, input logic [SYM_W-1:0] a,
			input logic [SYM_W-1:0] b, input bit typed, input pair_result_t want);
		int           gap;
		pair_result_t predicted;
		gap = $urandom_range(0, idle_max);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {b, a};
		s_axis_tuser  <= mode;
		do @(posedge clk); while (!s_axis_tready);
		predicted   = tally_pair(mode, a, b);
		results_due = {results_due, (typed ? want : predicted)};
	endtask

	// hold off input until every pending result is back
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		int unsigned      roll;
		logic             mode;
		logic [SYM_W-1:0] a;
		logic [SYM_W-1:0] b;
		logic [KEY_W-1:0] key;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = MODE_COUNT;
		entries_used  = 0;
		mismatches    = 0;
		results_seen  = 0;
		idle_max      = 14;
		arst_n        = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_pair(directed_rows[i].mode, directed_rows[i].a, directed_rows[i].b,
				directed_rows[i].typed, directed_rows[i].want);
		settle();

		// mostly pair-encoding traffic: repeats, pairs of bytes and earlier entries
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % SEGMENT_LEN == 0)
				idle_max = ((n / SEGMENT_LEN) % 3 == 2) ? 0 : 14;
			if (n == RANDOM_ITEMS / 2)
				settle();
			roll = $urandom_range(0, 99);
			mode = ($urandom_range(0, 99) < 80) ? MODE_COUNT : MODE_LOOKUP;
			if (roll < 45 && known_keys.size() != 0) begin
				key = known_keys[$urandom_range(0, known_keys.size() - 1)];
				a   = key[KEY_W-1:SYM_W];
				b   = key[SYM_W-1:0];
			end else if (roll < 75) begin
				a = ($urandom_range(0, 1) == 0 || entries_used == 0) ?
					SYM_W'($urandom_range(0, 255)) :
					SYM_W'($urandom_range(0, entries_used - 1));
				b = ($urandom_range(0, 1) == 0 || entries_used == 0) ?
					12'd0 : SYM_W'($urandom_range(0, entries_used - 1));
			end else begin
				mode = (roll < 90) ? MODE_LOOKUP : MODE_COUNT;
				a    = SYM_W'($urandom);
				b    = SYM_W'($urandom);
			end
			send_pair(mode, a, b, 1'b0, '0);
		end
		settle();

		// fill the table, then probe it: inserts must fail, hits must still count
		idle_max = 14;
		while (entries_used < TABLE_DEPTH)
			send_pair(MODE_COUNT, SYM_W'($urandom), SYM_W'($urandom), 1'b0, '0);
		for (int n = 0; n < FULL_PROBES; n++) begin
			key = known_keys[$urandom_range(0, known_keys.size() - 1)];
			case (n % 4)
				0: send_pair(MODE_COUNT, SYM_W'($urandom), SYM_W'($urandom), 1'b0, '0);
				1: send_pair(MODE_COUNT, key[KEY_W-1:SYM_W], key[SYM_W-1:0], 1'b0, '0);
				2: send_pair(MODE_LOOKUP, key[KEY_W-1:SYM_W], key[SYM_W-1:0], 1'b0, '0);
				default: send_pair(MODE_LOOKUP, SYM_W'($urandom), SYM_W'($urandom), 1'b0,
					'0);
			endcase
		end
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin : result_sink
		int           stall;
		pair_result_t got;
		pair_result_t want;
		m_axis_tready = 1'b0;
		forever begin
			stall = $urandom_range(0, idle_max);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			got.entry_index = m_axis_tdata[11:0];
			got.count       = m_axis_tdata[43:12];
			got.found       = m_axis_tuser[0];
			got.created     = m_axis_tuser[1];
			got.full        = m_axis_tuser[2];
			if (results_due.size() == 0) begin
				report_mismatch("result with nothing pending, entry_index",
					CNT_W'(got.entry_index), '0);
			end else begin
				want = results_due.pop_front();
				check_field("entry_index", CNT_W'(got.entry_index), CNT_W'(want.entry_index));
				check_field("found", CNT_W'(got.found), CNT_W'(want.found));
				check_field("created", CNT_W'(got.created), CNT_W'(want.created));
				check_field("pair_count", got.count, want.count);
				check_field("table_full", CNT_W'(got.full), CNT_W'(want.full));
			end
			results_seen++;
		end
	end

	// end the run when no transfer happens on either side for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
